// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold whenever the antecedent holds in the same cycle
`define EMCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after the antecedent
`define EMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/emct_pkg.sv -----
// ----------------------------------------------------------------------------
// emct_pkg
// shared types and constants of the execution marker capture table
// ----------------------------------------------------------------------------
package emct_pkg;

    // default sizing
    localparam int DEF_MARKER_COUNT = 8;
    localparam int DEF_ADDRESS_BITS = 24;

    // field widths
    localparam int ADDR_W  = 24;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 6;   // holds an entry number or the table size (up to 63)

    localparam logic [WORD_W-1:0] NOT_MARKED = '1;

    // request kinds
    typedef enum logic [2:0] {
        KIND_EXEC     = 3'd0,
        KIND_ADD_FREE = 3'd1,
        KIND_ADD_AT   = 3'd2,
        KIND_COMPLETE = 3'd3,
        KIND_CLEAR    = 3'd4,
        KIND_ZERO     = 3'd5,
        KIND_READ     = 3'd6
    } kind_t;

    // marker status
    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_STARTED  = 2'd1,
        ST_COMPLETE = 2'd2
    } status_t;

    // request broadcast to every cell
    typedef struct packed {
        logic              fire;
        kind_t             kind;
        logic [2:0]        entry_index;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] frame;
        logic [WORD_W-1:0] cycle;
    } emct_cmd_t;

    // one entry as seen on the read bus
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [WORD_W-1:0] start_frame;
        logic [WORD_W-1:0] start_cycle;
        logic [WORD_W-1:0] end_frame;
        logic [WORD_W-1:0] end_cycle;
    } emct_entry_t;

    // data handed from one cell to the next
    typedef struct packed {
        logic [IDX_W-1:0] free_idx;   // lowest free entry so far, table size if none
        logic [IDX_W-1:0] busy_idx;   // lowest started entry after the request
        emct_entry_t      rd;         // read data passed along the row
    } emct_link_t;

endpackage

// ----- src/execution_marker_capture_table_core.sv -----
// ----------------------------------------------------------------------------
// execution_marker_capture_table_core
// table of debug markers built as a row of entry cells with a registered
// result stage
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  request   in         in_valid / in_ready   kind, entry_index, address,
//                                             frame_number, cycle_number
//  result    out        out_valid / out_ready result_index .. in_progress_index
//
//  one request per cycle while results are taken; its result appears in the cycle after acceptance
//  the first-free and first-started searches ripple through the cell row
//  in_ready is high while the result register is empty or being taken
//  reset frees every entry, zeroes addresses and unmarks all captures
// ----------------------------------------------------------------------------
module execution_marker_capture_table_core #(
    parameter int MARKER_COUNT = emct_pkg::DEF_MARKER_COUNT,
    parameter int ADDRESS_BITS = emct_pkg::DEF_ADDRESS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [2:0]  entry_index,
    input  logic [23:0] address,
    input  logic [31:0] frame_number,
    input  logic [31:0] cycle_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  result_index,
    output logic [1:0]  entry_status,
    output logic [23:0] entry_start_address,
    output logic [23:0] entry_end_address,
    output logic [31:0] entry_start_frame,
    output logic [31:0] entry_start_cycle,
    output logic [31:0] entry_end_frame,
    output logic [31:0] entry_end_cycle,
    output logic [3:0]  in_progress_index
);
    import emct_pkg::*;

    localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(MARKER_COUNT);

    emct_cmd_t   cmd;
    emct_link_t  link [MARKER_COUNT+1];
    logic        fire;
    logic [IDX_W-1:0] res_idx;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  result_index_reg;
    logic [3:0]  in_progress_reg;
    emct_entry_t entry_reg;

    // request broadcast
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cmd.fire        = fire;
        cmd.kind        = kind_t'(kind);
        cmd.entry_index = entry_index;
        cmd.address     = address;
        cmd.frame       = frame_number;
        cmd.cycle       = cycle_number;
    end

    // head of the cell row
    always_comb
    begin
        link[0].free_idx = NONE_IDX;
        link[0].busy_idx = NONE_IDX;
        link[0].rd       = '0;
    end

    // row of entry cells
    for (genvar i = 0; i < MARKER_COUNT; i++)
    begin : g_cell
        emct_cell #(
            .CELL_ID      (i),
            .MARKER_COUNT (MARKER_COUNT),
            .AW           (AW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    // reported entry number
    always_comb
    begin
        case (cmd.kind)
            KIND_ADD_FREE:                        res_idx = link[MARKER_COUNT].free_idx;
            KIND_ADD_AT, KIND_COMPLETE, KIND_READ: res_idx = IDX_W'(entry_index);
            default:                              res_idx = '0;
        endcase
    end

    // result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_index_reg <= res_idx[3:0];
            in_progress_reg  <= link[MARKER_COUNT].busy_idx[3:0];
            entry_reg        <= link[MARKER_COUNT].rd;
        end
    end

    assign out_valid           = out_valid_reg;
    assign result_index        = result_index_reg;
    assign in_progress_index   = in_progress_reg;
    assign entry_status        = entry_reg.status;
    assign entry_start_address = entry_reg.start_addr;
    assign entry_end_address   = entry_reg.end_addr;
    assign entry_start_frame   = entry_reg.start_frame;
    assign entry_start_cycle   = entry_reg.start_cycle;
    assign entry_end_frame     = entry_reg.end_frame;
    assign entry_end_cycle     = entry_reg.end_cycle;

    // checks
`include "assert_macros.svh"

    `EMCT_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg, "accepted request without result")
    `EMCT_ASSERT_NEXT(a_stall_holds, out_valid_reg && !out_ready, out_valid_reg && $stable(result_index_reg) && $stable(entry_reg), "stalled result changed")
    `EMCT_ASSERT_SAME(a_busy_range, 1'b1, link[MARKER_COUNT].busy_idx <= NONE_IDX, "started search out of range")
    `EMCT_ASSERT_SAME(a_free_range, 1'b1, link[MARKER_COUNT].free_idx <= NONE_IDX, "free search out of range")

endmodule

// ----- src/emct_cell.sv -----
// ----------------------------------------------------------------------------
// emct_cell
// one marker entry: holds its state, updates it per request and passes
// the search and read data on to the next cell
// ----------------------------------------------------------------------------
module emct_cell #(
    parameter int CELL_ID      = 0,
    parameter int MARKER_COUNT = emct_pkg::DEF_MARKER_COUNT,
    parameter int AW           = emct_pkg::DEF_ADDRESS_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  emct_pkg::emct_cmd_t cmd,
    input  emct_pkg::emct_link_t link_in,
    output emct_pkg::emct_link_t link_out
);
    import emct_pkg::*;

    localparam logic [IDX_W-1:0] MY_ID    = IDX_W'(CELL_ID);
    localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(MARKER_COUNT);

    status_t           status_reg, status_next;
    logic [AW-1:0]     start_addr_reg, start_addr_next;
    logic [AW-1:0]     end_addr_reg, end_addr_next;
    logic [WORD_W-1:0] start_frame_reg, start_frame_next;
    logic [WORD_W-1:0] start_cycle_reg, start_cycle_next;
    logic [WORD_W-1:0] end_frame_reg, end_frame_next;
    logic [WORD_W-1:0] end_cycle_reg, end_cycle_next;

    logic          hit;
    logic          alloc;
    logic [AW-1:0] addr;
    emct_entry_t   own;

    // request decode for this entry
    assign addr  = cmd.address[AW-1:0];
    assign hit   = (IDX_W'(cmd.entry_index) == MY_ID);
    assign alloc = (link_in.free_idx == NONE_IDX) && (status_reg == ST_FREE);

    // entry update
    always_comb
    begin
        status_next      = status_reg;
        start_addr_next  = start_addr_reg;
        end_addr_next    = end_addr_reg;
        start_frame_next = start_frame_reg;
        start_cycle_next = start_cycle_reg;
        end_frame_next   = end_frame_reg;
        end_cycle_next   = end_cycle_reg;
        if (cmd.fire)
        begin
            case (cmd.kind)
                KIND_EXEC:
                begin
                    if (status_reg == ST_STARTED || status_reg == ST_COMPLETE)
                    begin
                        if (start_addr_reg == addr)
                        begin
                            start_frame_next = cmd.frame;
                            start_cycle_next = cmd.cycle;
                            end_cycle_next   = NOT_MARKED;
                        end
                        if (end_addr_reg == addr)
                        begin
                            end_frame_next = cmd.frame;
                            end_cycle_next = cmd.cycle;
                        end
                    end
                end
                KIND_ADD_FREE, KIND_ADD_AT:
                begin
                    if ((cmd.kind == KIND_ADD_FREE) ? alloc : hit)
                    begin
                        status_next      = ST_STARTED;
                        start_addr_next  = addr;
                        end_addr_next    = addr;
                        start_frame_next = NOT_MARKED;
                        start_cycle_next = NOT_MARKED;
                        end_frame_next   = NOT_MARKED;
                        end_cycle_next   = NOT_MARKED;
                    end
                end
                KIND_COMPLETE:
                begin
                    if (hit)
                    begin
                        status_next    = ST_COMPLETE;
                        end_addr_next  = addr;
                        end_frame_next = NOT_MARKED;
                        end_cycle_next = NOT_MARKED;
                    end
                end
                KIND_CLEAR:
                begin
                    status_next = ST_FREE;
                end
                KIND_ZERO:
                begin
                    start_frame_next = NOT_MARKED;
                    start_cycle_next = NOT_MARKED;
                    end_frame_next   = NOT_MARKED;
                    end_cycle_next   = NOT_MARKED;
                end
                default:
                begin
                end
            endcase
        end
    end

    // entry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= ST_FREE;
            start_addr_reg  <= '0;
            end_addr_reg    <= '0;
            start_frame_reg <= NOT_MARKED;
            start_cycle_reg <= NOT_MARKED;
            end_frame_reg   <= NOT_MARKED;
            end_cycle_reg   <= NOT_MARKED;
        end
        else
        begin
            status_reg      <= status_next;
            start_addr_reg  <= start_addr_next;
            end_addr_reg    <= end_addr_next;
            start_frame_reg <= start_frame_next;
            start_cycle_reg <= start_cycle_next;
            end_frame_reg   <= end_frame_next;
            end_cycle_reg   <= end_cycle_next;
        end
    end

    // current contents as read data
    always_comb
    begin
        own.status      = status_reg;
        own.start_addr  = ADDR_W'(start_addr_reg);
        own.end_addr    = ADDR_W'(end_addr_reg);
        own.start_frame = start_frame_reg;
        own.start_cycle = start_cycle_reg;
        own.end_frame   = end_frame_reg;
        own.end_cycle   = end_cycle_reg;
    end

    // hand searches and read data to the next cell
    always_comb
    begin
        link_out.free_idx = alloc ? MY_ID : link_in.free_idx;
        link_out.busy_idx = (link_in.busy_idx == NONE_IDX && status_next == ST_STARTED)
                            ? MY_ID : link_in.busy_idx;
        link_out.rd       = (cmd.kind == KIND_READ && hit) ? own : link_in.rd;
    end

endmodule

// ----- sim/tb_execution_marker_capture_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_execution_marker_capture_table_core
// self-checking bench for the execution marker capture table: a table of
// directed requests, then random request streams mostly on a small pool of
// addresses, under four idle/stall mixes; every result is compared field by
// field against a behavioral copy of the marker table or against a
// typed-in result
module tb_execution_marker_capture_table_core;
    import emct_pkg::*;

    localparam int MARKERS        = DEF_MARKER_COUNT;
    localparam int HOT_ADDRS      = 6;
    localparam int PHASES         = 4;
    localparam int RANDOM_PER_PH  = 450;
    localparam int DIRECTED_ROWS  = 25;
    localparam int TAIL_CYCLES    = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PRINT_CAP      = 40;

    // one result as the table should report it
    typedef struct packed {
        logic [3:0]  index;
        emct_entry_t entry;
        logic [3:0]  busy;
    } marker_result_t;

    // one directed request, with a typed-in result where fixed is set
    typedef struct packed {
        kind_t          kind;
        logic [2:0]     idx;
        logic [23:0]    addr;
        logic [31:0]    frame;
        logic [31:0]    cyc;
        logic           fixed;
        marker_result_t reply;
    } stim_row_t;

    localparam emct_entry_t NO_ENTRY    = '0;
    localparam emct_entry_t RESET_ENTRY = '{ST_FREE, 24'h0, 24'h0,
                                            NOT_MARKED, NOT_MARKED, NOT_MARKED, NOT_MARKED};

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [2:0]  req_kind    = '0;
    logic [2:0]  req_entry   = '0;
    logic [23:0] req_address = '0;
    logic [31:0] req_frame   = '0;
    logic [31:0] req_cycle   = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [3:0]  result_index;
    logic [1:0]  entry_status;
    logic [23:0] entry_start_address;
    logic [23:0] entry_end_address;
    logic [31:0] entry_start_frame;
    logic [31:0] entry_start_cycle;
    logic [31:0] entry_end_frame;
    logic [31:0] entry_end_cycle;
    logic [3:0]  in_progress_index;

    // behavioral copy of the marker table
    status_t     mk_status      [MARKERS];
    logic [23:0] mk_start_addr  [MARKERS];
    logic [23:0] mk_end_addr    [MARKERS];
    logic [31:0] mk_start_frame [MARKERS];
    logic [31:0] mk_start_cycle [MARKERS];
    logic [31:0] mk_end_frame   [MARKERS];
    logic [31:0] mk_end_cycle   [MARKERS];

    marker_result_t replies_due [$];
    logic [23:0]    hot_addr [HOT_ADDRS];
    logic [31:0]    run_frame = '0;
    logic [31:0]    run_cycle = '0;
    int             sender_idle_pct    = 0;
    int             receiver_stall_pct = 0;
    int             mismatch_count     = 0;
    int             replies_checked    = 0;
    int             table_full_count   = 0;
    int             kind_count [8]     = '{default: 0};
    int             cycle_count        = 0;

    // directed requests: extremes, every kind, start equal to end,
    // end capture cleared by a later start, complete on a free entry, full table
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_READ,     3'd0, 24'h000000, 32'd0, 32'd0, 1'b1, '{4'd0, RESET_ENTRY, 4'd8}},
        '{KIND_READ,     3'd7, 24'h000000, 32'd0, 32'd0, 1'b1, '{4'd7, RESET_ENTRY, 4'd8}},
        '{KIND_ADD_FREE, 3'd5, 24'hFFFFFF, 32'd0, 32'd0, 1'b1, '{4'd0, NO_ENTRY, 4'd0}},
        '{KIND_ADD_AT,   3'd7, 24'h000000, 32'd0, 32'd0, 1'b1, '{4'd7, NO_ENTRY, 4'd0}},
        '{KIND_EXEC, 3'd0, 24'hFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFE, 1'b1,
          '{4'd0, NO_ENTRY, 4'd0}},
        '{KIND_READ,     3'd0, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_EXEC,     3'd5, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_READ,     3'd7, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_COMPLETE, 3'd0, 24'h123456, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_EXEC,     3'd0, 24'h123456, 32'd10, 32'd11, 1'b0, '0},
        '{KIND_EXEC,     3'd0, 24'hFFFFFF, 32'd12, 32'd13, 1'b0, '0},
        '{KIND_READ,     3'd0, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_COMPLETE, 3'd3, 24'hABCDEF, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_READ,     3'd3, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_ADD_FREE, 3'd0, 24'h000100, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_ADD_FREE, 3'd0, 24'h000200, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_ADD_FREE, 3'd0, 24'h000300, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_ADD_FREE, 3'd0, 24'h000400, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_ADD_FREE, 3'd0, 24'h000500, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_ADD_FREE, 3'd0, 24'h000600, 32'd0, 32'd0, 1'b1, '{4'd8, NO_ENTRY, 4'd1}},
        '{KIND_ZERO,     3'd0, 24'h000000, 32'd0, 32'd0, 1'b1, '{4'd0, NO_ENTRY, 4'd1}},
        '{KIND_READ,     3'd0, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_CLEAR,    3'd0, 24'h000000, 32'd0, 32'd0, 1'b1, '{4'd0, NO_ENTRY, 4'd8}},
        '{KIND_READ,     3'd7, 24'h000000, 32'd0, 32'd0, 1'b0, '0},
        '{KIND_EXEC,     3'd0, 24'h000100, 32'd7, 32'd8, 1'b0, '0}
    };

    localparam int PHASE_IDLE  [PHASES] = '{0, 64, 0, 28};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 64, 28};

    execution_marker_capture_table_core DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .kind                (req_kind),
        .entry_index         (req_entry),
        .address             (req_address),
        .frame_number        (req_frame),
        .cycle_number        (req_cycle),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .result_index        (result_index),
        .entry_status        (entry_status),
        .entry_start_address (entry_start_address),
        .entry_end_address   (entry_end_address),
        .entry_start_frame   (entry_start_frame),
        .entry_start_cycle   (entry_start_cycle),
        .entry_end_frame     (entry_end_frame),
        .entry_end_cycle     (entry_end_cycle),
        .in_progress_index   (in_progress_index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // start a marker: both addresses set, all captures unmarked
    function automatic void arm_marker(input int e, input logic [23:0] addr);
        mk_status[e]      = ST_STARTED;
        mk_start_addr[e]  = addr;
        mk_end_addr[e]    = addr;
        mk_start_frame[e] = NOT_MARKED;
        mk_start_cycle[e] = NOT_MARKED;
        mk_end_frame[e]   = NOT_MARKED;
        mk_end_cycle[e]   = NOT_MARKED;
    endfunction

    // apply one request to the marker table and return its result
    function automatic marker_result_t apply_marker_request(
        input kind_t k, input logic [2:0] idx, input logic [23:0] addr,
        input logic [31:0] frame, input logic [31:0] cyc);
        marker_result_t r;
        int             slot;
        int             e;
        r    = '0;
        slot = MARKERS;
        case (k)
            KIND_EXEC:
            begin
                for (e = 0; e < MARKERS; e++)
                begin
                    if (mk_status[e] == ST_FREE)
                        continue;
                    // start match first, so start equal to end keeps this cycle
                    if (mk_start_addr[e] == addr)
                    begin
                        mk_start_frame[e] = frame;
                        mk_start_cycle[e] = cyc;
                        mk_end_cycle[e]   = NOT_MARKED;
                    end
                    if (mk_end_addr[e] == addr)
                    begin
                        mk_end_frame[e] = frame;
                        mk_end_cycle[e] = cyc;
                    end
                end
            end
            KIND_ADD_FREE:
            begin
                for (e = MARKERS - 1; e >= 0; e--)
                    if (mk_status[e] == ST_FREE)
                        slot = e;
                r.index = 4'(slot);
                if (slot < MARKERS)
                    arm_marker(slot, addr);
            end
            KIND_ADD_AT:
            begin
                r.index = 4'(idx);
                arm_marker(int'(idx), addr);
            end
            KIND_COMPLETE:
            begin
                r.index           = 4'(idx);
                mk_status[idx]    = ST_COMPLETE;
                mk_end_addr[idx]  = addr;
                mk_end_frame[idx] = NOT_MARKED;
                mk_end_cycle[idx] = NOT_MARKED;
            end
            KIND_CLEAR:
                for (e = 0; e < MARKERS; e++)
                    mk_status[e] = ST_FREE;
            KIND_ZERO:
                for (e = 0; e < MARKERS; e++)
                begin
                    mk_start_frame[e] = NOT_MARKED;
                    mk_start_cycle[e] = NOT_MARKED;
                    mk_end_frame[e]   = NOT_MARKED;
                    mk_end_cycle[e]   = NOT_MARKED;
                end
            KIND_READ:
            begin
                r.index = 4'(idx);
                r.entry = '{mk_status[idx], mk_start_addr[idx], mk_end_addr[idx],
                            mk_start_frame[idx], mk_start_cycle[idx],
                            mk_end_frame[idx], mk_end_cycle[idx]};
            end
            default: ;
        endcase
        // lowest started entry after the request
        slot = MARKERS;
        for (e = MARKERS - 1; e >= 0; e--)
            if (mk_status[e] == ST_STARTED)
                slot = e;
        r.busy = 4'(slot);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      replies_checked, name, got, want));
    endtask

    // present one request, hold it until taken, then record its result
    task automatic send_request(input kind_t k, input logic [2:0] idx,
                                input logic [23:0] addr, input logic [31:0] frame,
                                input logic [31:0] cyc, input logic fixed,
                                input marker_result_t fixed_reply);
        marker_result_t reply;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid    <= 1'b1;
        req_kind    <= k;
        req_entry   <= idx;
        req_address <= addr;
        req_frame   <= frame;
        req_cycle   <= cyc;
        do @(posedge clk); while (!in_ready);
        reply = apply_marker_request(k, idx, addr, frame, cyc);
        replies_due.push_back(fixed ? fixed_reply : reply);
        kind_count[int'(k)]++;
        if (k == KIND_ADD_FREE && reply.index == 4'(MARKERS))
            table_full_count++;
    endtask

    // random request, mostly on a small pool of marker addresses
    task automatic random_request();
        kind_t       k;
        int          pick;
        logic [23:0] addr;
        pick = $urandom_range(99);
        if (pick < 48)
            k = KIND_EXEC;
        else if (pick < 66)
            k = KIND_READ;
        else if (pick < 75)
            k = KIND_ADD_FREE;
        else if (pick < 84)
            k = KIND_ADD_AT;
        else if (pick < 93)
            k = KIND_COMPLETE;
        else if (pick < 96)
            k = KIND_ZERO;
        else
            k = KIND_CLEAR;
        if ($urandom_range(99) < 80)
            addr = hot_addr[$urandom_range(HOT_ADDRS - 1)];
        else
            addr = 24'($urandom);
        // frame and cycle counters mostly run forward, now and then jump
        if ($urandom_range(19) == 0)
        begin
            run_frame = $urandom_range(32'hFFFFFFFE);
            run_cycle = $urandom_range(32'hFFFFFFFE);
        end
        else
        begin
            run_cycle = run_cycle + $urandom_range(1, 40);
            if ($urandom_range(9) == 0)
                run_frame = run_frame + 1;
        end
        if (run_cycle == NOT_MARKED)
            run_cycle = '0;
        if (run_frame == NOT_MARKED)
            run_frame = '0;
        send_request(k, 3'($urandom_range(7)), addr, run_frame, run_cycle, 1'b0, '0);
    endtask

    // hold off new requests until every result is back
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // result side: compare against the oldest outstanding request, random stalls
    always @(posedge clk)
    begin : result_monitor
        marker_result_t want;
        if (out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = replies_due.pop_front();
                check_field("result_index", 32'(result_index), 32'(want.index));
                check_field("entry_status", 32'(entry_status), 32'(want.entry.status));
                check_field("entry_start_address", 32'(entry_start_address),
                            32'(want.entry.start_addr));
                check_field("entry_end_address", 32'(entry_end_address),
                            32'(want.entry.end_addr));
                check_field("entry_start_frame", entry_start_frame, want.entry.start_frame);
                check_field("entry_start_cycle", entry_start_cycle, want.entry.start_cycle);
                check_field("entry_end_frame", entry_end_frame, want.entry.end_frame);
                check_field("entry_end_cycle", entry_end_cycle, want.entry.end_cycle);
                check_field("in_progress_index", 32'(in_progress_index), 32'(want.busy));
                replies_checked++;
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, replies_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int e;
        int ph;
        int row;
        for (e = 0; e < MARKERS; e++)
        begin
            arm_marker(e, '0);
            mk_status[e] = ST_FREE;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (row = 0; row < DIRECTED_ROWS; row++)
            send_request(directed_rows[row].kind, directed_rows[row].idx,
                         directed_rows[row].addr, directed_rows[row].frame,
                         directed_rows[row].cyc, directed_rows[row].fixed,
                         directed_rows[row].reply);
        wait_for_replies();

        // random streams under each idle/stall mix
        for (ph = 0; ph < PHASES; ph++)
        begin
            sender_idle_pct    = PHASE_IDLE[ph];
            receiver_stall_pct = PHASE_STALL[ph];
            hot_addr[0] = 24'h000000;
            hot_addr[1] = 24'hFFFFFF;
            for (e = 2; e < HOT_ADDRS; e++)
                hot_addr[e] = 24'($urandom);
            repeat (RANDOM_PER_PH) random_request();
            wait_for_replies();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", replies_due.size()));

        $display("requests: %0d execute, %0d read, %0d add free, %0d add at, %0d complete,"
                 , kind_count[KIND_EXEC], kind_count[KIND_READ], kind_count[KIND_ADD_FREE],
                 kind_count[KIND_ADD_AT], kind_count[KIND_COMPLETE]);
        $display("  %0d clear, %0d zero; %0d results checked, %0d adds on a full table",
                 kind_count[KIND_CLEAR], kind_count[KIND_ZERO], replies_checked,
                 table_full_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
